// File: src/clc_pkg.sv
// Shared types and constants for the competitive learning cluster core.
// No dependencies.
package clc_pkg;

  localparam int unsigned NumClustersDef = 8;
  localparam int unsigned VectorLenDef   = 16;
  localparam int unsigned ElemW          = 16;
  localparam int unsigned DistW          = 36;
  localparam int unsigned EpochW         = 10;
  localparam int unsigned ActionW        = 2;
  localparam int unsigned ClusterW       = 3;
  localparam int unsigned IndexW         = 4;

  localparam logic [ActionW-1:0] ActLoad     = 2'd0;
  localparam logic [ActionW-1:0] ActClassify = 2'd1;
  localparam logic [ActionW-1:0] ActTrain    = 2'd2;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [ClusterW-1:0] cluster;
    logic [IndexW-1:0]   element;
    logic [ElemW-1:0]    value;
    logic                last;
  } item_t;

endpackage

// File: src/competitive_learning_cluster_core.sv
// Top level: input queue front end, execution back end, result register.
// Depends on clc_pkg, clc_item_queue, clc_engine.
// The queue buffers items ahead of the engine. Load: one store write from idle. Classify/train
// element: read, wait and add per cluster, plus a square step if the difference is nonzero
// (one shared multiplier walks the clusters). Last element adds a search and an emit; train adds
// read, wait, 16-step serial divide and write per element. The result registers when emit is taken.
// Reset clears control state and distances; the prototype store is undefined until written.
module competitive_learning_cluster_core #(
  parameter int unsigned NumClusters = clc_pkg::NumClustersDef,
  parameter int unsigned VectorLen   = clc_pkg::VectorLenDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [clc_pkg::ActionW-1:0]    action_i,
  input  logic [clc_pkg::ClusterW-1:0]   cluster_index_i,
  input  logic [clc_pkg::IndexW-1:0]     element_index_i,
  input  logic [clc_pkg::ElemW-1:0]      element_value_i,
  input  logic                           last_element_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [clc_pkg::ClusterW-1:0]   winner_cluster_o,
  output logic [clc_pkg::DistW-1:0]      winner_distance_sq_o,
  output logic                           was_training_o,
  input  logic                           cfg_we_i,
  input  logic [clc_pkg::EpochW-1:0]     cfg_wdata_i
);

  logic [clc_pkg::EpochW-1:0] epoch_q;
  clc_pkg::item_t in_item, q_item;
  logic q_empty, q_pop;
  logic res_valid, res_train, out_valid_q;
  logic [clc_pkg::ClusterW-1:0] res_cluster;
  logic [clc_pkg::DistW-1:0] res_dist;

  assign in_item = '{action: action_i, cluster: cluster_index_i,
                     element: element_index_i, value: element_value_i,
                     last: last_element_i};

  clc_item_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_item),
    .full_o (full),
    .pop_i  (q_pop),
    .data_o (q_item),
    .empty_o(q_empty)
  );

  clc_engine #(.NumClusters(NumClusters), .VectorLen(VectorLen)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .epoch_i      (epoch_q),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (res_valid),
    .res_cluster_o(res_cluster),
    .res_dist_o   (res_dist),
    .res_train_o  (res_train),
    .res_free_i   (!out_valid_q || pop)
  );

  assign empty = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= clc_pkg::EpochW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) epoch_q <= cfg_wdata_i;
      if (res_valid && (!out_valid_q || pop)) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && (!out_valid_q || pop)) begin
      winner_cluster_o     <= res_cluster;
      winner_distance_sq_o <= res_dist;
      was_training_o       <= res_train;
    end
  end

endmodule

// File: src/clc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/clc_item_queue.sv
// Short item queue between the input front and the execution back end.
// Depends on clc_pkg.
module clc_item_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clc_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output clc_pkg::item_t data_o,
  output logic           empty_o
);

  localparam int unsigned Depth = clc_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  clc_pkg::item_t    buf_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: src/clc_divider.sv
// Iterative restoring divider: 16-bit magnitude by 10-bit epoch, one bit a cycle.
// Depends on clc_pkg.
module clc_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [clc_pkg::ElemW-1:0]    dividend_i,
  input  logic [clc_pkg::EpochW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [clc_pkg::ElemW-1:0]    quotient_o
);

  localparam int unsigned W  = clc_pkg::ElemW;
  localparam int unsigned DW = clc_pkg::EpochW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  assign trial      = {rem_q[DW-1:0], quo_q[W-1]};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

// File: src/clc_engine.sv
// Back end: prototype loading, sample buffering, distance accumulation, winner search and update.
// Depends on clc_pkg, clc_ram and clc_divider.
module clc_engine #(
  parameter int unsigned NumClusters = clc_pkg::NumClustersDef,
  parameter int unsigned VectorLen   = clc_pkg::VectorLenDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [clc_pkg::EpochW-1:0]     epoch_i,
  input  logic                           item_valid_i,
  input  clc_pkg::item_t                 item_i,
  output logic                           item_pop_o,
  output logic                           res_valid_o,
  output logic [clc_pkg::ClusterW-1:0]   res_cluster_o,
  output logic [clc_pkg::DistW-1:0]      res_dist_o,
  output logic                           res_train_o,
  input  logic                           res_free_i
);

  localparam int unsigned CW  = $clog2(NumClusters);
  localparam int unsigned EW  = (VectorLen > 1) ? $clog2(VectorLen) : 1;
  localparam int unsigned AW  = $clog2(NumClusters * VectorLen);
  localparam int unsigned W   = clc_pkg::ElemW;
  localparam int unsigned DW  = clc_pkg::DistW;
  localparam int unsigned CCW = $clog2(NumClusters + 1);
  localparam int unsigned ECW = $clog2(VectorLen + 1);

  typedef enum logic [3:0] {
    StIdle, StAccRead, StAccWait, StAccAdd, StSearch,
    StUpdRead, StUpdWait, StUpdDiv, StUpdWrite, StEmit
  } state_e;

  state_e             state_q;
  clc_pkg::item_t     it_q;
  logic [DW-1:0]      dist_q [NumClusters];
  logic [CCW-1:0]     cidx_q;
  logic [ECW-1:0]     eidx_q;
  logic [CW-1:0]      win_q;
  logic [DW-1:0]      best_q;
  logic [W-1:0]       wval_q;
  logic [W-1:0]       sval_q;
  logic               up_q;
  logic [W-1:0]       diff_q;
  logic [2*W-1:0]     sq_q;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [W-1:0]       wdata, rdata;
  logic [W-1:0]       sbuf_q [VectorLen];
  logic               sb_ok;
  logic [EW-1:0]      sb_idx;
  logic               div_start, div_done;
  logic [W-1:0]       div_quo;
  logic [clc_pkg::EpochW-1:0] epoch_eff;
  logic [DW:0]        acc_sum;
  logic [W-1:0]       absdiff;

  clc_ram #(.Width(W), .Depth(NumClusters * VectorLen)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign epoch_eff = (epoch_i == '0) ? clc_pkg::EpochW'(1) : epoch_i;

  clc_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(absdiff),
    .divisor_i (epoch_eff),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign sb_ok  = ({28'd0, item_i.element} < 32'(VectorLen));
  assign sb_idx = EW'(item_i.element);

  assign absdiff = (sval_q >= rdata) ? sval_q - rdata : rdata - sval_q;
  assign acc_sum = {1'b0, dist_q[cidx_q[CW-1:0]]} + {{(DW+1-2*W){1'b0}}, sq_q};

  assign item_pop_o    = (state_q == StIdle) && item_valid_i;
  assign res_valid_o   = (state_q == StEmit);
  assign res_cluster_o = clc_pkg::ClusterW'(win_q);
  assign res_dist_o    = best_q;
  assign res_train_o   = (it_q.action == clc_pkg::ActTrain);
  assign div_start     = (state_q == StUpdWait);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state_q)
      StIdle: begin
        if (item_valid_i && item_i.action == clc_pkg::ActLoad
            && {29'd0, item_i.cluster} < 32'(NumClusters) && sb_ok) begin
          we    = 1'b1;
          waddr = AW'(item_i.cluster) * AW'(VectorLen) + AW'(item_i.element);
          wdata = item_i.value;
        end
      end
      StAccRead: raddr = AW'(cidx_q) * AW'(VectorLen) + AW'(it_q.element);
      StUpdRead: raddr = AW'(win_q) * AW'(VectorLen) + AW'(eidx_q);
      StUpdWrite: begin
        we    = 1'b1;
        waddr = AW'(win_q) * AW'(VectorLen) + AW'(eidx_q);
        wdata = up_q ? wval_q + div_quo : wval_q - div_quo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sq_q    <= '0;
      for (int i = 0; i < NumClusters; i++) dist_q[i] <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            it_q   <= item_i;
            cidx_q <= '0;
            if (item_i.action == clc_pkg::ActClassify
                || item_i.action == clc_pkg::ActTrain) begin
              if (sb_ok) begin
                sbuf_q[sb_idx] <= item_i.value;
                state_q <= StAccRead;
              end else if (item_i.last) begin
                state_q <= StSearch;
              end
            end
          end
        end
        StAccRead: state_q <= StAccWait;
        StAccWait: begin
          diff_q <= (rdata >= it_q.value) ? rdata - it_q.value : it_q.value - rdata;
          state_q <= StAccAdd;
        end
        StAccAdd: begin
          if (sq_q == '0 && diff_q != '0) begin
            sq_q <= diff_q * diff_q;
            diff_q <= '0;
          end else begin
            sq_q <= '0;
            dist_q[cidx_q[CW-1:0]] <= acc_sum[DW] ? clc_pkg::DistMax : acc_sum[DW-1:0];
            if (cidx_q == CCW'(NumClusters - 1)) begin
              cidx_q  <= '0;
              state_q <= it_q.last ? StSearch : StIdle;
            end else begin
              cidx_q  <= cidx_q + 1'b1;
              state_q <= StAccRead;
            end
          end
        end
        StSearch: begin
          if (cidx_q == '0) begin
            best_q <= dist_q[0];
            win_q  <= '0;
          end else if (dist_q[cidx_q[CW-1:0]] < best_q) begin
            best_q <= dist_q[cidx_q[CW-1:0]];
            win_q  <= cidx_q[CW-1:0];
          end
          if (cidx_q == CCW'(NumClusters - 1)) begin
            eidx_q  <= '0;
            state_q <= (it_q.action == clc_pkg::ActTrain) ? StUpdRead : StEmit;
            for (int i = 0; i < NumClusters; i++) dist_q[i] <= '0;
          end else begin
            cidx_q <= cidx_q + 1'b1;
          end
        end
        StUpdRead: state_q <= StUpdWait;
        StUpdWait: begin
          state_q <= StUpdDiv;
        end
        StUpdDiv: begin
          if (div_done) state_q <= StUpdWrite;
        end
        StUpdWrite: begin
          if (eidx_q == ECW'(VectorLen - 1)) begin
            state_q <= StEmit;
          end else begin
            eidx_q  <= eidx_q + 1'b1;
            state_q <= StUpdRead;
          end
        end
        StEmit: begin
          if (res_free_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // latch update operands: sample value in the read state, stored value and direction in the read-wait state
  always_ff @(posedge clk_i) begin
    if (state_q == StUpdRead) begin
      sval_q <= sbuf_q[eidx_q[EW-1:0]];
    end
    if (state_q == StUpdWait) begin
      wval_q <= rdata;
      up_q   <= (sval_q >= rdata);
    end
  end

endmodule
